FILE: hdl/playfair_digraph_cipher_macros.svh
// Assertion helpers for the digraph cipher block.
`ifndef PLAYFAIR_DIGRAPH_CIPHER_MACROS_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, masked in reset.
`define PFDC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, masked in reset.
`define PFDC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/pfdc_pkg.sv
`default_nettype none
package pfdc_pkg;

   localparam logic [4:0] LETTER_I = 5'd8;
   localparam logic [4:0] LETTER_J = 5'd9;
   localparam logic [4:0] LETTER_X = 5'd23;
   localparam logic [4:0] LETTER_Z = 5'd25;
   localparam int         SIDE     = 5;
   localparam int         ALPHABET = 26;
   localparam int         SQ_SIZE  = SIDE * SIDE;

   localparam logic [2:0] CMD_CLEAR   = 3'd0;
   localparam logic [2:0] CMD_KEY     = 3'd1;
   localparam logic [2:0] CMD_CLOSE   = 3'd2;
   localparam logic [2:0] CMD_ENCRYPT = 3'd3;
   localparam logic [2:0] CMD_DECRYPT = 3'd4;

   typedef struct packed {
      logic [2:0] command;
      logic [4:0] letter_a;
      logic [4:0] letter_b;
      logic       message_end;
   } req_type;

   typedef struct packed {
      logic [4:0] first_out;
      logic [4:0] second_out;
      logic       run_last;
   } rsp_type;

   // codes above z read as z
   function automatic logic [4:0] clamp_letter(input logic [4:0] l);
      return (l > LETTER_Z) ? LETTER_Z : l;
   endfunction

   function automatic logic [4:0] fold_j(input logic [4:0] l);
      return (l == LETTER_J) ? LETTER_I : l;
   endfunction

   // row of a square position, small compare chain instead of a divide
   function automatic logic [2:0] pos_row(input logic [4:0] pos);
      logic [2:0] r;
      if (pos >= 5'd20) begin
         r = 3'd4;
      end else if (pos >= 5'd15) begin
         r = 3'd3;
      end else if (pos >= 5'd10) begin
         r = 3'd2;
      end else if (pos >= 5'd5) begin
         r = 3'd1;
      end else begin
         r = 3'd0;
      end
      return r;
   endfunction

   function automatic logic [2:0] pos_col(input logic [4:0] pos);
      logic [2:0] r;
      logic [4:0] c;
      r = pos_row(pos);
      c = pos - {r, 2'b00} - {2'b00, r};
      return c[2:0];
   endfunction

   // one step along a row or column with wrap; back one step when decrypting
   function automatic logic [2:0] wrap_step(input logic [2:0] v, input logic dec);
      logic [2:0] r;
      if (dec) begin
         r = (v == 3'd0) ? 3'(SIDE - 1) : v - 3'd1;
      end else begin
         r = (v >= 3'(SIDE - 1)) ? 3'd0 : v + 3'd1;
      end
      return r;
   endfunction

   function automatic logic [4:0] sq_addr(input logic [2:0] r, input logic [2:0] c);
      return {r, 2'b00} + {2'b00, r} + {2'b00, c};
   endfunction

endpackage
`default_nettype wire

FILE: hdl/playfair_digraph_cipher.sv
`default_nettype none
// Playfair cipher over letters a=0 .. z=25 with a 5x5 key square.
// Request channel (req_valid/req_ready/req_data) carries one command word:
// clear key, key letter, close key, encrypt letter or decrypt digraph.
// Response channel (rsp_valid/rsp_ready/rsp_data) carries one digraph word;
// run_last marks the final response of a request. An encrypt request gives
// zero, one or two responses, a decrypt request exactly one.
// Clear key and key letter leave the block ready for the next request. Close
// key walks the 26 letters, one per cycle, into the square.
// Each digraph goes through one shared lookup unit: position memory read,
// square address compute and square memory read, so a response is valid
// once the square read is registered and the unit then waits for it.
// req_ready is low while a request is in work or a response is pending.
// When the receiver stalls, the response word holds in its register and
// nothing else advances until it is taken; a second digraph of the same
// request starts the cycle after the first is taken.
// Synchronous reset clears the key state and any held plaintext letter; the
// square contents are undefined until a close key has run.
module playfair_digraph_cipher (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_ready,
   input  pfdc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_ready,
   output pfdc_pkg::rsp_type rsp_data
);
   import pfdc_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_FILL = 3'd1;
   localparam logic [2:0] S_POS  = 3'd2;
   localparam logic [2:0] S_KEY  = 3'd3;
   localparam logic [2:0] S_WAIT = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [4:0]  fill_ff, fill_in;
   logic [ALPHABET-1:0] used_ff, used_in;
   logic [4:0]  held_ff, held_in;
   logic        held_vld_ff, held_vld_in;
   logic [4:0]  walk_ff, walk_in;
   logic [4:0]  cur_a_ff, cur_a_in;
   logic [4:0]  cur_b_ff, cur_b_in;
   logic        cur_dec_ff, cur_dec_in;
   logic        cur_last_ff, cur_last_in;
   logic [4:0]  nxt_a_ff, nxt_a_in;
   logic        pend_ff, pend_in;
   logic        rsp_vld_ff, rsp_vld_in;

   logic [4:0]  key_square [SQ_SIZE];
   logic [4:0]  letter_position [ALPHABET];
   logic [4:0]  pos_a_ff, pos_b_ff;
   logic [4:0]  key_a_ff, key_b_ff;

   logic        req_acc;
   logic [4:0]  la_c, lb_c, enc_l;
   logic [4:0]  place_letter;
   logic        place_en;
   logic [2:0]  ra, ca, rb, cb;
   logic [4:0]  adr_a, adr_b;

   assign req_ready = (state_ff == S_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign la_c      = clamp_letter(req_data.letter_a);
   assign lb_c      = clamp_letter(req_data.letter_b);
   assign enc_l     = fold_j(la_c);

   assign place_letter = (state_ff == S_FILL) ? walk_ff : la_c;
   assign place_en = !used_ff[place_letter] && (place_letter != LETTER_J) &&
                     (fill_ff < 5'(SQ_SIZE)) &&
                     ((req_acc && req_data.command == CMD_KEY) || state_ff == S_FILL);

   // square addressing for the current digraph
   assign ra = pos_row(pos_a_ff);
   assign ca = pos_col(pos_a_ff);
   assign rb = pos_row(pos_b_ff);
   assign cb = pos_col(pos_b_ff);

   always_comb begin
      if (ra == rb) begin
         adr_a = sq_addr(ra, wrap_step(ca, cur_dec_ff));
         adr_b = sq_addr(rb, wrap_step(cb, cur_dec_ff));
      end else if (ca == cb) begin
         adr_a = sq_addr(wrap_step(ra, cur_dec_ff), ca);
         adr_b = sq_addr(wrap_step(rb, cur_dec_ff), cb);
      end else begin
         adr_a = sq_addr(ra, cb);
         adr_b = sq_addr(rb, ca);
      end
   end

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      used_in     = used_ff;
      held_in     = held_ff;
      held_vld_in = held_vld_ff;
      walk_in     = walk_ff;
      cur_a_in    = cur_a_ff;
      cur_b_in    = cur_b_ff;
      cur_dec_in  = cur_dec_ff;
      cur_last_in = cur_last_ff;
      nxt_a_in    = nxt_a_ff;
      pend_in     = pend_ff;
      rsp_vld_in  = rsp_vld_ff;
      if (place_en) begin
         used_in[place_letter] = 1'b1;
         fill_in = fill_ff + 5'd1;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               case (req_data.command)
                  CMD_CLEAR: begin
                     used_in     = '0;
                     fill_in     = 5'd0;
                     held_in     = 5'd0;
                     held_vld_in = 1'b0;
                  end
                  CMD_CLOSE: begin
                     walk_in  = 5'd0;
                     state_in = S_FILL;
                  end
                  CMD_ENCRYPT: begin
                     cur_dec_in = 1'b0;
                     pend_in    = 1'b0;
                     if (held_vld_ff) begin
                        cur_a_in = held_ff;
                        state_in = S_POS;
                        if (held_ff == enc_l) begin
                           // doubled letter: pad x; new one held or pended
                           cur_b_in = LETTER_X;
                           if (req_data.message_end) begin
                              pend_in     = 1'b1;
                              nxt_a_in    = enc_l;
                              cur_last_in = 1'b0;
                              held_in     = 5'd0;
                              held_vld_in = 1'b0;
                           end else begin
                              cur_last_in = 1'b1;
                              held_in     = enc_l;
                              held_vld_in = 1'b1;
                           end
                        end else begin
                           cur_b_in    = enc_l;
                           cur_last_in = 1'b1;
                           held_in     = 5'd0;
                           held_vld_in = 1'b0;
                        end
                     end else if (req_data.message_end) begin
                        cur_a_in    = enc_l;
                        cur_b_in    = LETTER_Z;
                        cur_last_in = 1'b1;
                        state_in    = S_POS;
                     end else begin
                        held_in     = enc_l;
                        held_vld_in = 1'b1;
                     end
                  end
                  CMD_DECRYPT: begin
                     cur_a_in    = la_c;
                     cur_b_in    = lb_c;
                     cur_dec_in  = 1'b1;
                     cur_last_in = 1'b1;
                     pend_in     = 1'b0;
                     state_in    = S_POS;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_FILL: begin
            walk_in = walk_ff + 5'd1;
            if (walk_ff == 5'(ALPHABET - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_POS: begin
            state_in = S_KEY;
         end
         S_KEY: begin
            rsp_vld_in = 1'b1;
            state_in   = S_WAIT;
         end
         S_WAIT: begin
            if (rsp_ready) begin
               rsp_vld_in = 1'b0;
               if (pend_ff) begin
                  // odd tail after a doubled pair: pad with z
                  cur_a_in    = nxt_a_ff;
                  cur_b_in    = LETTER_Z;
                  cur_last_in = 1'b1;
                  pend_in     = 1'b0;
                  state_in    = S_POS;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         fill_ff     <= 5'd0;
         used_ff     <= '0;
         held_ff     <= 5'd0;
         held_vld_ff <= 1'b0;
         walk_ff     <= 5'd0;
         pend_ff     <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         used_ff     <= used_in;
         held_ff     <= held_in;
         held_vld_ff <= held_vld_in;
         walk_ff     <= walk_in;
         pend_ff     <= pend_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_a_ff    <= cur_a_in;
      cur_b_ff    <= cur_b_in;
      cur_dec_ff  <= cur_dec_in;
      cur_last_ff <= cur_last_in;
      nxt_a_ff    <= nxt_a_in;
   end

   // letter -> square position
   always_ff @(posedge clock) begin
      if (place_en) begin
         letter_position[place_letter] <= fill_ff;
      end
      if (state_ff == S_POS) begin
         pos_a_ff <= letter_position[fold_j(cur_a_ff)];
         pos_b_ff <= letter_position[fold_j(cur_b_ff)];
      end
   end

   // square position -> letter; read data doubles as the response word
   always_ff @(posedge clock) begin
      if (place_en) begin
         key_square[fill_ff] <= place_letter;
      end
      if (state_ff == S_KEY) begin
         key_a_ff <= key_square[adr_a];
         key_b_ff <= key_square[adr_b];
      end
   end

   assign rsp_valid           = rsp_vld_ff;
   assign rsp_data.first_out  = key_a_ff;
   assign rsp_data.second_out = key_b_ff;
   assign rsp_data.run_last   = cur_last_ff;

`include "playfair_digraph_cipher_macros.svh"

   `PFDC_ASSERT_NOW(a_busy_when_rsp, rsp_valid, !req_ready, "request taken with response pending")
   `PFDC_ASSERT_NOW(a_fill_bound, 1'b1, fill_ff <= 5'(SQ_SIZE), "square fill count overrun")
   `PFDC_ASSERT_NEXT(a_close_fills, state_ff == S_FILL && walk_ff == 5'(ALPHABET - 1),
                     fill_ff == 5'(SQ_SIZE), "close key left square short")
   `PFDC_ASSERT_NEXT(a_pad_follows, rsp_valid && rsp_ready && pend_ff,
                     state_ff == S_POS && cur_b_ff == LETTER_Z, "tail pad digraph not started")
   `PFDC_ASSERT_NOW(a_pend_not_last, rsp_valid && pend_ff, !rsp_data.run_last,
                    "run_last set before tail pad word")

endmodule
`default_nettype wire

FILE: dv/digraph_checker.sv
`timescale 1ns / 100ps
module digraph_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  pfdc_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  pfdc_pkg::rsp_type rsp_data,
   output int                mismatch_count,
   output int                words_due
);
   import pfdc_pkg::*;

   logic [4:0] square [0:SQ_SIZE-1];
   logic [4:0] spot [0:ALPHABET-1];
   bit         used [0:ALPHABET-1];
   int         fill;
   logic [4:0] held;
   bit         held_v;
   rsp_type    digraph_queue [$];

   initial mismatch_count = 0;

   task automatic clear_key_state();
      foreach (used[k]) used[k] = 1'b0;
      fill   = 0;
      held   = '0;
      held_v = 1'b0;
   endtask

   task automatic put_letter(input logic [4:0] l);
      if (fill < SQ_SIZE) begin
         square[fill] = l;
         spot[l]      = 5'(fill);
         used[l]      = 1'b1;
         fill++;
      end
   endtask

   // row / column / rectangle rule; back steps the other way for decrypt
   function automatic rsp_type digraph(input logic [4:0] a, input logic [4:0] b,
                                       input bit back);
      int pa, pb, ra, ca, rb, cb, step;
      rsp_type r;
      if (a == LETTER_J) a = LETTER_I;
      if (b == LETTER_J) b = LETTER_I;
      step = back ? SIDE - 1 : 1;
      pa = int'(spot[a]) % SQ_SIZE;
      pb = int'(spot[b]) % SQ_SIZE;
      ra = pa / SIDE;
      ca = pa % SIDE;
      rb = pb / SIDE;
      cb = pb % SIDE;
      if (ra == rb) begin
         r.first_out  = square[ra * SIDE + (ca + step) % SIDE];
         r.second_out = square[rb * SIDE + (cb + step) % SIDE];
      end else if (ca == cb) begin
         r.first_out  = square[((ra + step) % SIDE) * SIDE + ca];
         r.second_out = square[((rb + step) % SIDE) * SIDE + cb];
      end else begin
         r.first_out  = square[ra * SIDE + cb];
         r.second_out = square[rb * SIDE + ca];
      end
      r.run_last = 1'b0;
      return r;
   endfunction

   task automatic take_request(input req_type w);
      logic [4:0] la, lb;
      rsp_type    outs [$];
      int         k;
      la = (w.letter_a > LETTER_Z) ? LETTER_Z : w.letter_a;
      lb = (w.letter_b > LETTER_Z) ? LETTER_Z : w.letter_b;
      case (w.command)
         CMD_CLEAR: begin
            clear_key_state();
         end
         CMD_KEY: begin
            if (la != LETTER_J && !used[la]) put_letter(la);
         end
         CMD_CLOSE: begin
            for (k = 0; k < ALPHABET; k++)
               if (5'(k) != LETTER_J && !used[k]) put_letter(5'(k));
         end
         CMD_ENCRYPT: begin
            if (la == LETTER_J) la = LETTER_I;
            if (held_v) begin
               // doubled letter: pad with x, the new one stays held
               if (held == la) begin
                  outs.push_back(digraph(held, LETTER_X, 1'b0));
               end else begin
                  outs.push_back(digraph(held, la, 1'b0));
                  held_v = 1'b0;
                  held   = '0;
               end
            end else begin
               held   = la;
               held_v = 1'b1;
            end
            if (w.message_end && held_v) begin
               outs.push_back(digraph(held, LETTER_Z, 1'b0));
               held_v = 1'b0;
               held   = '0;
            end
         end
         CMD_DECRYPT: begin
            outs.push_back(digraph(la, lb, 1'b1));
         end
         default: ;
      endcase
      if (outs.size() > 0) outs[outs.size() - 1].run_last = 1'b1;
      for (k = 0; k < outs.size(); k++) digraph_queue.push_back(outs[k]);
   endtask

   task automatic check_word(input rsp_type got);
      rsp_type want;
      if (digraph_queue.size() == 0) begin
         $error("unexpected rsp word: first_out %0d second_out %0d run_last %0d",
                got.first_out, got.second_out, got.run_last);
         mismatch_count++;
      end else begin
         want = digraph_queue.pop_front();
         if (got.first_out !== want.first_out) begin
            $error("first_out: expected %0d, actual %0d", want.first_out, got.first_out);
            mismatch_count++;
         end
         if (got.second_out !== want.second_out) begin
            $error("second_out: expected %0d, actual %0d", want.second_out, got.second_out);
            mismatch_count++;
         end
         if (got.run_last !== want.run_last) begin
            $error("run_last: expected %0d, actual %0d", want.run_last, got.run_last);
            mismatch_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_key_state();
         foreach (square[k]) square[k] = '0;
         foreach (spot[k]) spot[k] = '0;
         digraph_queue.delete();
      end else begin
         // a word leaving now can never come from the request taken now
         if (rsp_valid && rsp_ready) check_word(rsp_data);
         if (req_valid && req_ready) take_request(req_data);
      end
      words_due <= digraph_queue.size();
   end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
module tb;
   import pfdc_pkg::*;

   localparam logic [2:0] CMD_UNUSED   = 3'd7;
   localparam int         ITEM_TARGET  = 1500;
   localparam int         QUIET_LIMIT  = 2000;
   localparam int         HOLD_CYCLES  = 250;
   localparam int         SETTLE       = 40;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   int      mismatch_count;
   int      words_due;

   int      plain_items = 0;
   int      words_sent  = 0;
   int      calm_left   = 0;
   int      quiet       = 0;

   always #10 clock = ~clock;

   playfair_digraph_cipher dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   digraph_checker cipher_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .words_due      (words_due)
   );

   function automatic logic [4:0] ch(input byte c);
      return 5'(c - "a");
   endfunction

   function automatic req_type cmd_word(input logic [2:0] cmd, input logic [4:0] a,
                                        input logic [4:0] b, input logic e);
      req_type w;
      w.command     = cmd;
      w.letter_a    = a;
      w.letter_b    = b;
      w.message_end = e;
      return w;
   endfunction

   // mostly real letters, now and then a code above z
   function automatic logic [4:0] pick_letter();
      return ($urandom_range(0, 19) == 0) ? 5'($urandom_range(26, 31))
                                          : 5'($urandom_range(0, 25));
   endfunction

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic offer_word(input req_type w);
      int gap;
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
      if (w.command <= CMD_DECRYPT) plain_items++;
      gap = (calm_left > 0) ? 0 : idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop sending until every expected word is back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_due != 0) @(posedge clock);
   endtask

   task automatic run_sequence();
      int         r, n, k;
      logic [4:0] prev, l;
      bit         open_end;
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 14) == 0) calm_left = $urandom_range(5, 20);
      r = $urandom_range(0, 99);
      if (r < 8) begin
         offer_word(cmd_word(CMD_CLEAR, pick_letter(), pick_letter(), 1'($urandom)));
         n = $urandom_range(0, 20);
         for (k = 0; k < n; k++)
            offer_word(cmd_word(CMD_KEY, pick_letter(), pick_letter(), 1'($urandom)));
         if ($urandom_range(0, 7) != 0)
            offer_word(cmd_word(CMD_CLOSE, pick_letter(), pick_letter(), 1'($urandom)));
      end else if (r < 60) begin
         n        = $urandom_range(1, 12);
         open_end = ($urandom_range(0, 9) == 0);
         prev     = pick_letter();
         for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 11);
            if (r < 2) l = prev;
            else if (r == 2) l = (prev == LETTER_I) ? LETTER_J : LETTER_I;
            else l = pick_letter();
            offer_word(cmd_word(CMD_ENCRYPT, l, pick_letter(),
                                (k == n - 1) && !open_end));
            prev = l;
         end
      end else if (r < 85) begin
         offer_word(cmd_word(CMD_DECRYPT, pick_letter(), pick_letter(), 1'($urandom)));
      end else begin
         offer_word(cmd_word(3'($urandom_range(0, 7)), 5'($urandom), 5'($urandom),
                             1'($urandom)));
      end
   endtask

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // key: j dropped, repeat dropped, code 31 taken as z
      offer_word(cmd_word(CMD_KEY, LETTER_J, '0, 1'b0));
      offer_word(cmd_word(CMD_KEY, ch("m"), '0, 1'b0));
      offer_word(cmd_word(CMD_KEY, ch("o"), '0, 1'b0));
      offer_word(cmd_word(CMD_KEY, ch("n"), '0, 1'b0));
      offer_word(cmd_word(CMD_KEY, ch("a"), '0, 1'b0));
      offer_word(cmd_word(CMD_KEY, ch("r"), '0, 1'b0));
      offer_word(cmd_word(CMD_KEY, ch("c"), '0, 1'b0));
      offer_word(cmd_word(CMD_KEY, 5'd31, '0, 1'b0));
      offer_word(cmd_word(CMD_KEY, ch("m"), '0, 1'b0));
      offer_word(cmd_word(CMD_CLOSE, '0, '0, 1'b0));
      offer_word(cmd_word(CMD_CLOSE, '0, '0, 1'b0));
      offer_word(cmd_word(CMD_KEY, ch("b"), '0, 1'b0));
      // doubling through j read as i, then doubling plus odd tail at end
      offer_word(cmd_word(CMD_ENCRYPT, LETTER_I, '0, 1'b0));
      offer_word(cmd_word(CMD_ENCRYPT, LETTER_J, '0, 1'b0));
      offer_word(cmd_word(CMD_ENCRYPT, LETTER_I, '0, 1'b1));
      offer_word(cmd_word(CMD_ENCRYPT, LETTER_X, 5'd31, 1'b0));
      offer_word(cmd_word(CMD_ENCRYPT, LETTER_X, '0, 1'b0));
      offer_word(cmd_word(CMD_ENCRYPT, ch("a"), '0, 1'b0));
      offer_word(cmd_word(CMD_ENCRYPT, LETTER_Z, '0, 1'b1));
      offer_word(cmd_word(CMD_ENCRYPT, 5'd31, '0, 1'b1));
      // same row wrapping from column 0, same column, j with code 31, same letter
      offer_word(cmd_word(CMD_DECRYPT, ch("m"), ch("o"), 1'b0));
      offer_word(cmd_word(CMD_DECRYPT, ch("m"), ch("c"), 1'b1));
      offer_word(cmd_word(CMD_DECRYPT, LETTER_J, 5'd31, 1'b0));
      offer_word(cmd_word(CMD_DECRYPT, LETTER_X, LETTER_X, 1'b0));
      offer_word(cmd_word(CMD_UNUSED, 5'd31, 5'd31, 1'b1));
      drain();

      while (plain_items < ITEM_TARGET) run_sequence();
      drain();
      repeat (SETTLE) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // response side: random stalls, calm stretches and one long hold-off
   initial begin
      int  r;
      int  n;
      bit  held_off;
      held_off = 1'b0;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held_off && words_sent >= 300) begin
            held_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         r = $urandom_range(0, 99);
         if (r < 20) begin
            n = $urandom_range(20, 80);
            rsp_ready <= 1'b1;
         end else if (r < 75) begin
            n = $urandom_range(1, 4);
            rsp_ready <= 1'b1;
         end else if (r < 95) begin
            n = $urandom_range(1, 3);
            rsp_ready <= 1'b0;
         end else begin
            n = $urandom_range(10, 40);
            rsp_ready <= 1'b0;
         end
         repeat (n) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

endmodule
